// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the list engine modules.
// Stand-alone header: no package or module dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SLE_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SLE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/sle_pkg.sv =====
// Shared types and constants of the sequential list engine.
// Used by sle_ctrl, sle_dpath and sequential_list_engine; no dependencies.
package sle_pkg;

   localparam int CAPACITY_DEFAULT = 256;

   localparam int CMD_W = 3;
   localparam int POS_W = 9;
   localparam int VAL_W = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_DELETE = 3'd2,
      CMD_GET    = 3'd3,
      CMD_LOCATE = 3'd4,
      CMD_PRIOR  = 3'd5,
      CMD_NEXT   = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BADPOS   = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4,
      ST_NONEIGH  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_POS_M1,
      IDX_COUNT,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   // Pending write set up in this cycle, committed in the next one.
   typedef enum logic [1:0] {
      WR_NONE,
      WR_UP,      // address idx, data = word read this cycle
      WR_DOWN,    // address idx-1, data = word read this cycle
      WR_KEY      // address idx, data = latched value
   } wr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_CLEAR,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      VAL_HOLD,
      VAL_ZERO,
      VAL_RD,
      VAL_PREV
   } val_op_type;

   typedef struct packed {
      logic       load;
      idx_op_type idx_op;
      logic       rd_en;
      logic       rd_back;   // read at idx-1 instead of idx
      wr_op_type  wr_op;
      cnt_op_type cnt_op;
      val_op_type val_op;
      logic       prev_en;
      logic       finish;
      status_type status;
      logic       fpos_en;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             empty;
      logic             full;
      logic             pos_ok;
      logic             pos_ok_ins;
      logic             ins_done;
      logic             at_count;
      logic             at_first;
      logic             match;
   } dp_status_type;

endpackage

// ===== rtl/core/sequential_list_engine.sv =====
// Top level of the sequential list engine: ties the sequencer to the datapath.
// Depends on sle_pkg, sle_ctrl and sle_dpath.
//
// Ordered list of up to CAPACITY signed 32-bit words in a single-port-read
// memory. A command is taken when start is high and busy is low; its one
// result appears on the rsp_ ports for exactly one cycle with rsp_valid high,
// and the receiver cannot stall it, so capture it in that cycle. Busy drops
// in the strobe cycle, so the next command may be issued alongside it.
// Clear, unused commands and failed checks finish in the decode state; get
// reads the entry and then captures it; insert shifts entries up from the
// list end to the position; delete captures the entry, then shifts the rest
// down; locate, prior and next scan from the head, and next reads the match's
// following entry when there is one.
// The shift and scan loops move one entry per cycle through the memory's
// read port. The store needs no initialization pass after reset.
module sequential_list_engine #(
   parameter int CAPACITY = sle_pkg::CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [sle_pkg::CMD_W-1:0]         req_cmd,
   input  logic [sle_pkg::POS_W-1:0]         req_position,
   input  logic signed [sle_pkg::VAL_W-1:0]  req_value,
   output logic                              rsp_valid,
   output logic [2:0]                        rsp_status,
   output logic signed [sle_pkg::VAL_W-1:0]  rsp_result_value,
   output logic [sle_pkg::POS_W-1:0]         rsp_found_position,
   output logic [sle_pkg::POS_W-1:0]         rsp_list_length,
   output logic                              rsp_is_empty
);

   sle_pkg::dp_cmd_type    dp_cmd;
   sle_pkg::dp_status_type dp_status;

   sle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   sle_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_cmd),
      .req_position       (req_position),
      .req_value          (req_value),
      .dp_cmd             (dp_cmd),
      .dp_status          (dp_status),
      .rsp_status         (rsp_status),
      .rsp_result_value   (rsp_result_value),
      .rsp_found_position (rsp_found_position),
      .rsp_list_length    (rsp_list_length),
      .rsp_is_empty       (rsp_is_empty)
   );

endmodule

// ===== rtl/core/sle_dpath.sv =====
// Datapath of the list engine: entry memory, entry count, scan pointer,
// pending-write stage and result registers. Uses sle_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sle_dpath #(
   parameter int CAPACITY = sle_pkg::CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [sle_pkg::CMD_W-1:0]         req_cmd,
   input  logic [sle_pkg::POS_W-1:0]         req_position,
   input  logic signed [sle_pkg::VAL_W-1:0]  req_value,
   input  sle_pkg::dp_cmd_type               dp_cmd,
   output sle_pkg::dp_status_type            dp_status,
   output logic [2:0]                        rsp_status,
   output logic signed [sle_pkg::VAL_W-1:0]  rsp_result_value,
   output logic [sle_pkg::POS_W-1:0]         rsp_found_position,
   output logic [sle_pkg::POS_W-1:0]         rsp_list_length,
   output logic                              rsp_is_empty
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = ((CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W) + 1;

   logic [sle_pkg::VAL_W-1:0] mem [CAPACITY];

   logic [sle_pkg::CMD_W-1:0] cmd_ff;
   logic [sle_pkg::POS_W-1:0] pos_ff;
   logic [sle_pkg::VAL_W-1:0] key_ff;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [sle_pkg::VAL_W-1:0] rd_data_ff;
   logic [sle_pkg::VAL_W-1:0] prev_ff;
   logic                      wr_pend_ff, wr_pend_in;
   logic [AW-1:0]             wr_addr_ff, wr_addr_in;
   logic                      wr_key_ff;
   sle_pkg::status_type       status_ff;
   logic [sle_pkg::VAL_W-1:0] value_ff, value_in;
   logic [sle_pkg::POS_W-1:0] fpos_ff;

   logic [PW-1:0] pos_x, cnt_x, idx_x;
   logic [CW-1:0] idx_m1;
   logic [AW-1:0] rd_addr;

   assign pos_x  = PW'(pos_ff);
   assign cnt_x  = PW'(count_ff);
   assign idx_x  = PW'(idx_ff);
   assign idx_m1 = idx_ff - CW'(1);

   assign dp_status.cmd        = cmd_ff;
   assign dp_status.empty      = (count_ff == '0);
   assign dp_status.full       = (count_ff >= CW'(CAPACITY));
   assign dp_status.pos_ok     = (pos_x != '0) && (pos_x <= cnt_x);
   assign dp_status.pos_ok_ins = (pos_x != '0) && (pos_x <= cnt_x + PW'(1));
   assign dp_status.ins_done   = (idx_x + PW'(1) == pos_x);
   assign dp_status.at_count   = (idx_ff == count_ff);
   assign dp_status.at_first   = (idx_ff == CW'(1));
   assign dp_status.match      = (rd_data_ff == key_ff);

   assign rd_addr = dp_cmd.rd_back ? idx_m1[AW-1:0] : idx_ff[AW-1:0];

   always_comb begin
      unique case (dp_cmd.idx_op)
         sle_pkg::IDX_ZERO:   idx_in = '0;
         sle_pkg::IDX_POS_M1: idx_in = CW'(pos_x - PW'(1));
         sle_pkg::IDX_COUNT:  idx_in = count_ff;
         sle_pkg::IDX_INC:    idx_in = idx_ff + CW'(1);
         sle_pkg::IDX_DEC:    idx_in = idx_m1;
         default:             idx_in = idx_ff;
      endcase
   end

   always_comb begin
      unique case (dp_cmd.cnt_op)
         sle_pkg::CNT_CLEAR: count_in = '0;
         sle_pkg::CNT_INC:   count_in = count_ff + CW'(1);
         sle_pkg::CNT_DEC:   count_in = count_ff - CW'(1);
         default:            count_in = count_ff;
      endcase
   end

   always_comb begin
      unique case (dp_cmd.val_op)
         sle_pkg::VAL_ZERO: value_in = '0;
         sle_pkg::VAL_RD:   value_in = rd_data_ff;
         sle_pkg::VAL_PREV: value_in = prev_ff;
         default:           value_in = value_ff;
      endcase
   end

   always_comb begin
      wr_pend_in = (dp_cmd.wr_op != sle_pkg::WR_NONE);
      wr_addr_in = (dp_cmd.wr_op == sle_pkg::WR_DOWN) ? idx_m1[AW-1:0] : idx_ff[AW-1:0];
   end

   // Memory: one read and one (delayed) write per cycle.
   always_ff @(posedge clock) begin
      if (dp_cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_pend_ff) begin
         mem[wr_addr_ff] <= wr_key_ff ? key_ff : rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff <= req_cmd;
         pos_ff <= req_position;
         key_ff <= req_value;
      end
      idx_ff     <= idx_in;
      wr_addr_ff <= wr_addr_in;
      wr_key_ff  <= (dp_cmd.wr_op == sle_pkg::WR_KEY);
      value_ff   <= value_in;
      if (dp_cmd.prev_en) begin
         prev_ff <= rd_data_ff;
      end
      if (dp_cmd.finish) begin
         status_ff <= dp_cmd.status;
         fpos_ff   <= dp_cmd.fpos_en ? sle_pkg::POS_W'(idx_ff) : '0;
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_result_value   = value_ff;
   assign rsp_found_position = fpos_ff;
   assign rsp_list_length    = sle_pkg::POS_W'(count_ff);
   assign rsp_is_empty       = (count_ff == '0);

   `SLE_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY),
                    "count past capacity")
   `SLE_ASSERT_IMPL(a_count_step, clock, reset, count_ff != $past(count_ff),
                    (count_ff == $past(count_ff) + CW'(1)) ||
                    (count_ff == $past(count_ff) - CW'(1)) || (count_ff == '0),
                    "count jumped")
   `SLE_ASSERT_IMPL(a_write_in_list, clock, reset, wr_pend_ff, CW'(wr_addr_ff) <= count_ff,
                    "write beyond list end")

endmodule

// ===== rtl/core/sle_ctrl.sv =====
// Command sequencer of the list engine: decodes each word, steps the
// shift and scan loops and raises the result strobe. Uses sle_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sle_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_valid,
   output sle_pkg::dp_cmd_type    dp_cmd,
   input  sle_pkg::dp_status_type dp_status
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_SHIFT,
      S_GET_RD,
      S_GET_CAP,
      S_DEL_RD,
      S_DEL_CAP,
      S_DEL_SHIFT,
      S_SRCH_RD,
      S_SRCH,
      S_NEXT_CAP
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff;

   always_comb begin
      dp_cmd        = '0;
      dp_cmd.idx_op = sle_pkg::IDX_HOLD;
      dp_cmd.wr_op  = sle_pkg::WR_NONE;
      dp_cmd.cnt_op = sle_pkg::CNT_HOLD;
      dp_cmd.val_op = sle_pkg::VAL_HOLD;
      dp_cmd.status = sle_pkg::ST_OK;
      state_in      = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               dp_cmd.load = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            // Failing checks finish here with a zero value.
            dp_cmd.val_op = sle_pkg::VAL_ZERO;
            dp_cmd.finish = 1'b1;
            state_in      = S_IDLE;
            unique case (dp_status.cmd)
               sle_pkg::CMD_CLEAR: begin
                  dp_cmd.cnt_op = sle_pkg::CNT_CLEAR;
               end
               sle_pkg::CMD_INSERT: begin
                  priority if (!dp_status.pos_ok_ins) begin
                     dp_cmd.status = sle_pkg::ST_BADPOS;
                  end else if (dp_status.full) begin
                     dp_cmd.status = sle_pkg::ST_FULL;
                  end else begin
                     dp_cmd.finish = 1'b0;
                     dp_cmd.idx_op = sle_pkg::IDX_COUNT;
                     state_in      = S_INS_SHIFT;
                  end
               end
               sle_pkg::CMD_DELETE: begin
                  if (!dp_status.pos_ok) begin
                     dp_cmd.status = sle_pkg::ST_BADPOS;
                  end else begin
                     dp_cmd.finish = 1'b0;
                     dp_cmd.idx_op = sle_pkg::IDX_POS_M1;
                     state_in      = S_DEL_RD;
                  end
               end
               sle_pkg::CMD_GET: begin
                  priority if (dp_status.empty) begin
                     dp_cmd.status = sle_pkg::ST_EMPTY;
                  end else if (!dp_status.pos_ok) begin
                     dp_cmd.status = sle_pkg::ST_BADPOS;
                  end else begin
                     dp_cmd.finish = 1'b0;
                     dp_cmd.idx_op = sle_pkg::IDX_POS_M1;
                     state_in      = S_GET_RD;
                  end
               end
               sle_pkg::CMD_LOCATE, sle_pkg::CMD_PRIOR, sle_pkg::CMD_NEXT: begin
                  if (dp_status.empty) begin
                     dp_cmd.status = sle_pkg::ST_EMPTY;
                  end else begin
                     dp_cmd.finish = 1'b0;
                     dp_cmd.idx_op = sle_pkg::IDX_ZERO;
                     state_in      = S_SRCH_RD;
                  end
               end
               default: begin
               end
            endcase
         end
         S_INS_SHIFT: begin
            if (dp_status.ins_done) begin
               dp_cmd.wr_op  = sle_pkg::WR_KEY;
               dp_cmd.cnt_op = sle_pkg::CNT_INC;
               dp_cmd.val_op = sle_pkg::VAL_ZERO;
               dp_cmd.finish = 1'b1;
               state_in      = S_IDLE;
            end else begin
               // Move entry idx-1 up to idx, walk toward the insert point.
               dp_cmd.rd_en   = 1'b1;
               dp_cmd.rd_back = 1'b1;
               dp_cmd.wr_op   = sle_pkg::WR_UP;
               dp_cmd.idx_op  = sle_pkg::IDX_DEC;
            end
         end
         S_GET_RD: begin
            dp_cmd.rd_en = 1'b1;
            state_in     = S_GET_CAP;
         end
         S_GET_CAP: begin
            dp_cmd.val_op = sle_pkg::VAL_RD;
            dp_cmd.finish = 1'b1;
            state_in      = S_IDLE;
         end
         S_DEL_RD: begin
            dp_cmd.rd_en  = 1'b1;
            dp_cmd.idx_op = sle_pkg::IDX_INC;
            state_in      = S_DEL_CAP;
         end
         S_DEL_CAP, S_DEL_SHIFT: begin
            if (state_ff == S_DEL_CAP) begin
               dp_cmd.val_op = sle_pkg::VAL_RD;
            end
            if (dp_status.at_count) begin
               dp_cmd.cnt_op = sle_pkg::CNT_DEC;
               dp_cmd.finish = 1'b1;
               state_in      = S_IDLE;
            end else begin
               // Move entry idx down to idx-1.
               dp_cmd.rd_en  = 1'b1;
               dp_cmd.wr_op  = sle_pkg::WR_DOWN;
               dp_cmd.idx_op = sle_pkg::IDX_INC;
               state_in      = S_DEL_SHIFT;
            end
         end
         S_SRCH_RD: begin
            dp_cmd.rd_en  = 1'b1;
            dp_cmd.idx_op = sle_pkg::IDX_INC;
            state_in      = S_SRCH;
         end
         S_SRCH: begin
            // Read data holds entry idx-1; compare it while fetching entry idx.
            priority if (dp_status.match) begin
               dp_cmd.val_op = sle_pkg::VAL_ZERO;
               dp_cmd.finish = 1'b1;
               state_in      = S_IDLE;
               priority if (dp_status.cmd == sle_pkg::CMD_LOCATE) begin
                  dp_cmd.fpos_en = 1'b1;
               end else if (dp_status.cmd == sle_pkg::CMD_PRIOR) begin
                  if (dp_status.at_first) begin
                     dp_cmd.status = sle_pkg::ST_NONEIGH;
                  end else begin
                     dp_cmd.val_op = sle_pkg::VAL_PREV;
                  end
               end else begin
                  if (dp_status.at_count) begin
                     dp_cmd.status = sle_pkg::ST_NONEIGH;
                  end else begin
                     dp_cmd.finish = 1'b0;
                     dp_cmd.val_op = sle_pkg::VAL_HOLD;
                     dp_cmd.rd_en  = 1'b1;
                     state_in      = S_NEXT_CAP;
                  end
               end
            end else if (dp_status.at_count) begin
               dp_cmd.status = sle_pkg::ST_NOTFOUND;
               dp_cmd.val_op = sle_pkg::VAL_ZERO;
               dp_cmd.finish = 1'b1;
               state_in      = S_IDLE;
            end else begin
               dp_cmd.prev_en = 1'b1;
               dp_cmd.rd_en   = 1'b1;
               dp_cmd.idx_op  = sle_pkg::IDX_INC;
            end
         end
         S_NEXT_CAP: begin
            dp_cmd.val_op = sle_pkg::VAL_RD;
            dp_cmd.finish = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= dp_cmd.finish;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

   `SLE_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid, "strobe held two cycles")
   `SLE_ASSERT_IMPL(a_strobe_idle, clock, reset, rsp_valid, !busy, "strobe while busy")
   `SLE_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "accepted word not taken up")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sequential_list_engine: directed table, random
// command streams and a fill to capacity, each result checked on its strobe.
// Depends on sle_pkg and the sequential_list_engine RTL.
module tb;

   localparam int CMD_W = sle_pkg::CMD_W;
   localparam int POS_W = sle_pkg::POS_W;
   localparam int VAL_W = sle_pkg::VAL_W;
   localparam int CAPACITY = sle_pkg::CAPACITY_DEFAULT;
   localparam int WATCHDOG_LIMIT = 4 * (CAPACITY + 16);
   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

   typedef struct packed {
      sle_pkg::status_type      status;
      logic signed [VAL_W-1:0]  value;
      logic [POS_W-1:0]         fpos;
      logic [POS_W-1:0]         length;
      logic                     empty;
   } list_reply_type;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic [POS_W-1:0]         pos;
      logic signed [VAL_W-1:0]  value;
      logic                     fixed;
      list_reply_type           reply;
   } stim_row_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [CMD_W-1:0]          req_cmd = sle_pkg::CMD_CLEAR;
   logic [POS_W-1:0]          req_position = '0;
   logic signed [VAL_W-1:0]   req_value = '0;
   logic                      rsp_valid;
   logic [2:0]                rsp_status;
   logic signed [VAL_W-1:0]   rsp_result_value;
   logic [POS_W-1:0]          rsp_found_position;
   logic [POS_W-1:0]          rsp_list_length;
   logic                      rsp_is_empty;

   // shadow copy of the list, advanced at each accepted command
   logic signed [VAL_W-1:0]   list_mem [CAPACITY];
   int                        list_len = 0;

   list_reply_type            pending_replies[$];
   stim_row_type              directed_rows[$];
   int                        error_count = 0;
   int                        words_sent = 0;
   int                        replies_checked = 0;
   int                        full_hits = 0;
   int                        longest_list = 0;
   int                        idle_cycles = 0;

   sequential_list_engine #(.CAPACITY(CAPACITY)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_result_value(rsp_result_value),
      .rsp_found_position(rsp_found_position),
      .rsp_list_length(rsp_list_length),
      .rsp_is_empty(rsp_is_empty)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic list_reply_type apply_list_cmd(logic [CMD_W-1:0] c, logic [POS_W-1:0] p,
                                                     logic signed [VAL_W-1:0] v);
      list_reply_type r;
      int pos;
      int idx;
      int k;
      r.status = sle_pkg::ST_OK;
      r.value = '0;
      r.fpos = '0;
      pos = int'(p);
      case (c)
         sle_pkg::CMD_CLEAR: list_len = 0;
         sle_pkg::CMD_INSERT: begin
            if (pos < 1 || pos > list_len + 1) r.status = sle_pkg::ST_BADPOS;
            else if (list_len >= CAPACITY) r.status = sle_pkg::ST_FULL;
            else begin
               for (k = list_len; k > pos - 1; k--) list_mem[k] = list_mem[k-1];
               list_mem[pos-1] = v;
               list_len++;
            end
         end
         sle_pkg::CMD_DELETE: begin
            if (pos < 1 || pos > list_len) r.status = sle_pkg::ST_BADPOS;
            else begin
               r.value = list_mem[pos-1];
               for (k = pos; k < list_len; k++) list_mem[k-1] = list_mem[k];
               list_len--;
            end
         end
         sle_pkg::CMD_GET: begin
            if (list_len == 0) r.status = sle_pkg::ST_EMPTY;
            else if (pos < 1 || pos > list_len) r.status = sle_pkg::ST_BADPOS;
            else r.value = list_mem[pos-1];
         end
         sle_pkg::CMD_LOCATE, sle_pkg::CMD_PRIOR, sle_pkg::CMD_NEXT: begin
            if (list_len == 0) r.status = sle_pkg::ST_EMPTY;
            else begin
               idx = list_len;
               for (k = 0; k < list_len && idx == list_len; k++)
                  if (list_mem[k] == v) idx = k;
               if (idx == list_len) r.status = sle_pkg::ST_NOTFOUND;
               else if (c == sle_pkg::CMD_LOCATE) r.fpos = POS_W'(idx + 1);
               else if (c == sle_pkg::CMD_PRIOR) begin
                  if (idx == 0) r.status = sle_pkg::ST_NONEIGH;
                  else r.value = list_mem[idx-1];
               end else begin
                  if (idx + 1 >= list_len) r.status = sle_pkg::ST_NONEIGH;
                  else r.value = list_mem[idx+1];
               end
            end
         end
         default: ;
      endcase
      r.length = POS_W'(list_len);
      r.empty = (list_len == 0);
      return r;
   endfunction

   // Present one word, hold it until accepted, then log what it must produce.
   task automatic issue_word(logic [CMD_W-1:0] c, logic [POS_W-1:0] p,
                             logic signed [VAL_W-1:0] v, logic fixed, list_reply_type typed);
      list_reply_type predicted;
      start <= 1'b1;
      req_cmd <= c;
      req_position <= p;
      req_value <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = apply_list_cmd(c, p, v);
      if (predicted.status == sle_pkg::ST_FULL) full_hits++;
      pending_replies.push_back(fixed ? typed : predicted);
      words_sent++;
   endtask

   task automatic idle_gap(bit allowed);
      if (allowed && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic wait_for_replies();
      start <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   task automatic add_row(logic [CMD_W-1:0] c, logic [POS_W-1:0] p,
                          logic signed [VAL_W-1:0] v, logic fixed, sle_pkg::status_type st,
                          logic signed [VAL_W-1:0] rv, logic [POS_W-1:0] fp,
                          logic [POS_W-1:0] len);
      stim_row_type row;
      row.cmd = c;
      row.pos = p;
      row.value = v;
      row.fixed = fixed;
      row.reply.status = st;
      row.reply.value = rv;
      row.reply.fpos = fp;
      row.reply.length = len;
      row.reply.empty = (len == 0);
      directed_rows.push_back(row);
   endtask

   // Keys mostly hit the list; small values force duplicates.
   function automatic logic signed [VAL_W-1:0] pick_value(bit as_key);
      int sel;
      sel = $urandom_range(0, 9);
      if (as_key && list_len > 0 && sel < 6) return list_mem[$urandom_range(0, list_len - 1)];
      if (sel < 3) return $urandom_range(0, 8) - 4;
      if (sel == 9) begin
         case ($urandom_range(0, 3))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            default: return -1;
         endcase
      end
      return $urandom;
   endfunction

   task automatic pick_random_word(int len_cap, output logic [CMD_W-1:0] c,
                                   output logic [POS_W-1:0] p,
                                   output logic signed [VAL_W-1:0] v);
      int w;
      w = $urandom_range(0, 99);
      if (w < 38) c = sle_pkg::CMD_INSERT;
      else if (w < 58) c = sle_pkg::CMD_DELETE;
      else if (w < 70) c = sle_pkg::CMD_GET;
      else if (w < 80) c = sle_pkg::CMD_LOCATE;
      else if (w < 88) c = sle_pkg::CMD_PRIOR;
      else if (w < 96) c = sle_pkg::CMD_NEXT;
      else if (w < 98) c = sle_pkg::CMD_CLEAR;
      else c = CMD_UNUSED;
      // keep the list short so shifts and scans stay cheap
      if (c == sle_pkg::CMD_INSERT && list_len >= len_cap) c = sle_pkg::CMD_DELETE;
      if ($urandom_range(0, 9) < 8) begin
         if (c == sle_pkg::CMD_INSERT)
            p = POS_W'($urandom_range(1, list_len + 1));
         else
            p = POS_W'($urandom_range(1, (list_len == 0) ? 1 : list_len));
      end else
         p = POS_W'($urandom_range(0, 511));
      v = pick_value(c != sle_pkg::CMD_INSERT);
   endtask

   always @(posedge clock) begin
      list_reply_type exp;
      if (reset) idle_cycles <= 0;
      else if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_valid) begin
         if (pending_replies.size() == 0) begin
            $error("result word with no command pending");
            error_count++;
         end else begin
            exp = pending_replies.pop_front();
            replies_checked++;
            if (int'(rsp_list_length) > longest_list) longest_list = int'(rsp_list_length);
            if (rsp_status !== exp.status) begin
               $error("status: expected %0d, got %0d", exp.status, rsp_status);
               error_count++;
            end
            if (rsp_result_value !== exp.value) begin
               $error("result_value: expected %0d, got %0d", exp.value, rsp_result_value);
               error_count++;
            end
            if (rsp_found_position !== exp.fpos) begin
               $error("found_position: expected %0d, got %0d", exp.fpos, rsp_found_position);
               error_count++;
            end
            if (rsp_list_length !== exp.length) begin
               $error("list_length: expected %0d, got %0d", exp.length, rsp_list_length);
               error_count++;
            end
            if (rsp_is_empty !== exp.empty) begin
               $error("is_empty: expected %0d, got %0d", exp.empty, rsp_is_empty);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      do @(posedge clock); while (idle_cycles < WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      logic [CMD_W-1:0]         c;
      logic [POS_W-1:0]         p;
      logic signed [VAL_W-1:0]  v;
      list_reply_type           none;
      bit                       idle_on;
      int                       n;

      none = '0;
      add_row(sle_pkg::CMD_GET,    1,   0,       1, sle_pkg::ST_EMPTY,    0,       0, 0);
      add_row(sle_pkg::CMD_DELETE, 1,   0,       1, sle_pkg::ST_BADPOS,   0,       0, 0);
      add_row(sle_pkg::CMD_LOCATE, 0,   5,       1, sle_pkg::ST_EMPTY,    0,       0, 0);
      add_row(sle_pkg::CMD_PRIOR,  0,   5,       1, sle_pkg::ST_EMPTY,    0,       0, 0);
      add_row(sle_pkg::CMD_NEXT,   0,   5,       1, sle_pkg::ST_EMPTY,    0,       0, 0);
      add_row(sle_pkg::CMD_INSERT, 0,   1,       1, sle_pkg::ST_BADPOS,   0,       0, 0);
      add_row(sle_pkg::CMD_INSERT, 2,   1,       1, sle_pkg::ST_BADPOS,   0,       0, 0);
      add_row(sle_pkg::CMD_INSERT, 1,   VAL_MAX, 1, sle_pkg::ST_OK,       0,       0, 1);
      add_row(sle_pkg::CMD_INSERT, 1,   VAL_MIN, 1, sle_pkg::ST_OK,       0,       0, 2);
      add_row(sle_pkg::CMD_INSERT, 3,   -1,      1, sle_pkg::ST_OK,       0,       0, 3);
      add_row(sle_pkg::CMD_INSERT, 511, 0,       1, sle_pkg::ST_BADPOS,   0,       0, 3);
      add_row(sle_pkg::CMD_GET,    1,   0,       1, sle_pkg::ST_OK,       VAL_MIN, 0, 3);
      add_row(sle_pkg::CMD_GET,    3,   0,       1, sle_pkg::ST_OK,       -1,      0, 3);
      add_row(sle_pkg::CMD_GET,    4,   0,       1, sle_pkg::ST_BADPOS,   0,       0, 3);
      add_row(sle_pkg::CMD_GET,    0,   0,       1, sle_pkg::ST_BADPOS,   0,       0, 3);
      add_row(sle_pkg::CMD_LOCATE, 0,   VAL_MAX, 1, sle_pkg::ST_OK,       0,       2, 3);
      add_row(sle_pkg::CMD_LOCATE, 0,   12345,   1, sle_pkg::ST_NOTFOUND, 0,       0, 3);
      add_row(sle_pkg::CMD_PRIOR,  0,   VAL_MIN, 1, sle_pkg::ST_NONEIGH,  0,       0, 3);
      add_row(sle_pkg::CMD_PRIOR,  0,   VAL_MAX, 1, sle_pkg::ST_OK,       VAL_MIN, 0, 3);
      add_row(sle_pkg::CMD_NEXT,   0,   -1,      1, sle_pkg::ST_NONEIGH,  0,       0, 3);
      add_row(sle_pkg::CMD_NEXT,   0,   VAL_MIN, 1, sle_pkg::ST_OK,       VAL_MAX, 0, 3);
      add_row(sle_pkg::CMD_INSERT, 2,   32'h5a5a5a5a, 0, sle_pkg::ST_OK,  0,       0, 0);
      add_row(sle_pkg::CMD_INSERT, 2,   -1,      0, sle_pkg::ST_OK,       0,       0, 0);
      add_row(sle_pkg::CMD_LOCATE, 0,   -1,      0, sle_pkg::ST_OK,       0,       0, 0);
      add_row(CMD_UNUSED,          0,   0,       1, sle_pkg::ST_OK,       0,       0, 5);
      add_row(sle_pkg::CMD_DELETE, 2,   0,       0, sle_pkg::ST_OK,       0,       0, 0);
      add_row(sle_pkg::CMD_DELETE, 511, 0,       1, sle_pkg::ST_BADPOS,   0,       0, 4);
      add_row(sle_pkg::CMD_CLEAR,  0,   0,       1, sle_pkg::ST_OK,       0,       0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         idle_gap(1);
         issue_word(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].value,
                    directed_rows[i].fixed, directed_rows[i].reply);
      end
      wait_for_replies();

      // random mix on short lists, idling switched on and off in stretches
      idle_on = 1'b1;
      for (n = 0; n < 150; n++) begin
         if (n % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
         pick_random_word((n < 100) ? 12 : 48, c, p, v);
         idle_gap(idle_on);
         issue_word(c, p, v, 1'b0, none);
      end
      wait_for_replies();

      // fill to capacity by appending, then work the full list
      issue_word(sle_pkg::CMD_CLEAR, 0, 0, 1'b0, none);
      for (n = 0; n < CAPACITY; n++) begin
         idle_gap(n % 64 < 32);
         issue_word(sle_pkg::CMD_INSERT, POS_W'(list_len + 1), pick_value(1'b0), 1'b0, none);
      end
      issue_word(sle_pkg::CMD_INSERT, POS_W'(CAPACITY + 1), 7, 1'b0, none);
      issue_word(sle_pkg::CMD_INSERT, 1, 7, 1'b0, none);
      issue_word(sle_pkg::CMD_INSERT, POS_W'(CAPACITY + 2), 7, 1'b0, none);
      issue_word(sle_pkg::CMD_INSERT, 511, 7, 1'b0, none);
      issue_word(sle_pkg::CMD_GET, POS_W'(CAPACITY), 0, 1'b0, none);
      issue_word(sle_pkg::CMD_GET, 1, 0, 1'b0, none);
      issue_word(sle_pkg::CMD_LOCATE, 0, list_mem[CAPACITY-1], 1'b0, none);
      issue_word(sle_pkg::CMD_NEXT, 0, list_mem[CAPACITY-1], 1'b0, none);
      issue_word(sle_pkg::CMD_PRIOR, 0, list_mem[CAPACITY-1], 1'b0, none);
      issue_word(sle_pkg::CMD_PRIOR, 0, list_mem[0], 1'b0, none);
      issue_word(sle_pkg::CMD_DELETE, 1, 0, 1'b0, none);
      issue_word(sle_pkg::CMD_INSERT, 1, VAL_MIN, 1'b0, none);
      issue_word(sle_pkg::CMD_DELETE, POS_W'(CAPACITY), 0, 1'b0, none);
      for (n = 0; n < 20; n++) begin
         pick_random_word(CAPACITY, c, p, v);
         idle_gap(1);
         issue_word(c, p, v, 1'b0, none);
      end
      issue_word(sle_pkg::CMD_CLEAR, 0, 0, 1'b0, none);
      wait_for_replies();

      // closing stretch: back to back, no idling
      for (n = 0; n < 80; n++) begin
         pick_random_word(24, c, p, v);
         issue_word(c, p, v, 1'b0, none);
      end
      start <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);

      $display("tb: %0d commands driven, %0d results checked, %0d mismatches",
               words_sent, replies_checked, error_count);
      $display("tb: longest list %0d entries, full-list inserts refused %0d times",
               longest_list, full_hits);
      if (error_count == 0 && pending_replies.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== sequential_list_engine.f =====
+incdir+rtl/core
rtl/core/sle_pkg.sv
rtl/core/sle_dpath.sv
rtl/core/sle_ctrl.sv
rtl/core/sequential_list_engine.sv
sim/tb.sv
